[src/scdm_pkg.sv]
// scdm_pkg: types, constants and codes for the sparse column duplicate merge block.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package scdm_pkg;

  localparam int ROW_W   = 16;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 17;

  localparam longint ROW_COUNT       = 65536;
  localparam longint COLUMN_CAPACITY = 65536;
  localparam longint COUNT_MAX       = (64'd1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] KEPT_LIMIT =
    COUNT_W'((COLUMN_CAPACITY < COUNT_MAX) ? COLUMN_CAPACITY : COUNT_MAX);

  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;
  localparam int RES_CW    = 3;

  typedef enum logic [1:0] {
    OP_SUM  = 2'd0,
    OP_PROD = 2'd1,
    OP_AMAX = 2'd2,
    OP_AMIN = 2'd3
  } combine_t;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_CLOSE = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t              result_kind;
    logic [ROW_W-1:0]          out_row;
    logic signed [VALUE_W-1:0] out_value;
    logic [COUNT_W-1:0]        kept_count;
    logic                      last_result;
  } result_t;

endpackage

`default_nettype wire

[src/scdm_if.sv]
// scdm_if: valid/ready channel interfaces for entries, results and configuration.
// Depends on scdm_pkg.
`default_nettype none

interface scdm_in_if import scdm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      has_entry;
  logic [ROW_W-1:0]          row_index;
  logic signed [VALUE_W-1:0] entry_value;
  logic                      column_end;

  modport source (output valid, has_entry, row_index, entry_value, column_end, input ready);
  modport sink   (input valid, has_entry, row_index, entry_value, column_end, output ready);
endinterface

interface scdm_out_if import scdm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [ROW_W-1:0]          out_row;
  logic signed [VALUE_W-1:0] out_value;
  logic [COUNT_W-1:0]        kept_count;
  logic                      last_result;

  modport source (output valid, result_kind, out_row, out_value, kept_count, last_result,
                  input ready);
  modport sink   (input valid, result_kind, out_row, out_value, kept_count, last_result,
                  output ready);
endinterface

interface scdm_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[src/sparse_column_duplicate_merge.sv]
// sparse_column_duplicate_merge: merges neighbouring duplicate rows of a CSC entry stream.
// Depends on scdm_pkg and the channel interfaces in scdm_if.sv.
//
//   channel   dir   payload
//   entries   in    has_entry, row_index, entry_value, column_end
//   results   out   result_kind, out_row, out_value, kept_count, last_result
//   cfg       in    data = combine_op (2 bits), always ready
//
// One item per cycle: compare and combine against the pending entry happen at acceptance.
// Each item puts 0..3 items into a 4-slot result queue drained one per cycle; entries
// is ready while the queue holds at most one item, so single-result items flow back to back.
// Synchronous active-high reset clears the pending entry, count, queue and combine_op.
// A stalled results sink fills the queue and then holds entries off.
`default_nettype none

module sparse_column_duplicate_merge import scdm_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  scdm_cfg_if.sink    cfg,
  scdm_in_if.sink     entries,
  scdm_out_if.source  results
);

  combine_t                  combine_op;
  logic                      pending_valid;
  logic [ROW_W-1:0]          pending_row;
  logic signed [VALUE_W-1:0] pending_value;
  logic [COUNT_W-1:0]        column_kept;

  result_t                   slots [RES_DEPTH];
  logic [RES_AW-1:0]         head;
  logic [RES_CW-1:0]         count;

  logic                      pending_valid_next;
  logic [ROW_W-1:0]          pending_row_next;
  logic signed [VALUE_W-1:0] pending_value_next;
  logic [COUNT_W-1:0]        column_kept_next;

  result_t                   res [3];
  logic [1:0]                n_res;
  logic                      accept;
  logic                      deq;
  logic                      ent_ok;
  logic                      hit;
  logic                      new_ent;
  logic [VALUE_W-1:0]        merged;
  logic [RES_AW-1:0]         tail;

  function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? VALUE_W'(-v) : v;
  endfunction

  function automatic logic [VALUE_W-1:0] sat_mag(input logic [VALUE_W-1:0] m);
    logic [VALUE_W-1:0] lim;
    lim = {1'b0, {(VALUE_W-1){1'b1}}};
    return m[VALUE_W-1] ? lim : m;
  endfunction

  assign cfg.ready     = 1'b1;
  assign entries.ready = (count <= RES_CW'(1));
  assign accept        = entries.valid && entries.ready;
  assign deq           = results.valid && results.ready;
  assign tail          = RES_AW'(head + count[RES_AW-1:0]);

  always_comb begin
    logic [VALUE_W-1:0] ma;
    logic [VALUE_W-1:0] mb;
    ma = magnitude(pending_value);
    mb = magnitude(entries.entry_value);
    unique case (combine_op)
      OP_SUM:  merged = pending_value + entries.entry_value;
      OP_PROD: merged = VALUE_W'(pending_value * entries.entry_value);
      OP_AMAX: merged = sat_mag((ma > mb) ? ma : mb);
      OP_AMIN: merged = sat_mag((ma < mb) ? ma : mb);
    endcase
  end

  always_comb begin
    result_t r;
    ent_ok  = entries.has_entry && ({{(64-ROW_W){1'b0}}, entries.row_index} < ROW_COUNT);
    hit     = ent_ok && pending_valid && (pending_row == entries.row_index);
    new_ent = ent_ok && !hit;

    r.result_kind = KIND_ENTRY;
    r.out_row     = pending_row;
    r.out_value   = pending_value;
    r.kept_count  = '0;
    r.last_result = 1'b0;
    for (int i = 0; i < 3; i++) res[i] = r;
    n_res = 2'd0;

    if (new_ent && pending_valid) begin
      res[0] = r;
      n_res  = 2'd1;
    end

    pending_valid_next = pending_valid;
    pending_row_next   = pending_row;
    pending_value_next = pending_value;
    column_kept_next   = column_kept;
    if (new_ent) begin
      pending_valid_next = 1'b1;
      pending_row_next   = entries.row_index;
      pending_value_next = entries.entry_value;
      if (column_kept < KEPT_LIMIT) column_kept_next = column_kept + COUNT_W'(1);
    end else if (hit) begin
      pending_value_next = merged;
    end

    if (entries.column_end) begin
      if (pending_valid_next) begin
        r.out_row     = pending_row_next;
        r.out_value   = pending_value_next;
        res[n_res]    = r;
        n_res         = n_res + 2'd1;
      end
      r.result_kind = KIND_CLOSE;
      r.out_row     = '0;
      r.out_value   = '0;
      r.kept_count  = column_kept_next;
      res[n_res]    = r;
      n_res         = n_res + 2'd1;
      pending_valid_next = 1'b0;
      pending_row_next   = '0;
      pending_value_next = '0;
      column_kept_next   = '0;
    end

    if (n_res != 2'd0) res[n_res - 2'd1].last_result = 1'b1;
    if (!accept) n_res = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_op    <= OP_SUM;
      pending_valid <= 1'b0;
      pending_row   <= '0;
      pending_value <= '0;
      column_kept   <= '0;
      head          <= '0;
      count         <= '0;
    end else begin
      if (cfg.valid) combine_op <= combine_t'(cfg.data);
      if (accept) begin
        pending_valid <= pending_valid_next;
        pending_row   <= pending_row_next;
        pending_value <= pending_value_next;
        column_kept   <= column_kept_next;
      end
      if (deq) head <= head + RES_AW'(1);
      count <= count + RES_CW'(n_res) - RES_CW'(deq);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < RES_DEPTH; j++) begin
      logic [RES_AW-1:0] off;
      off = RES_AW'(RES_AW'(j) - tail);
      if ({1'b0, off} < {1'b0, n_res}) slots[j] <= res[off];
    end
  end

  assign results.valid       = (count != '0);
  assign results.result_kind = slots[head].result_kind;
  assign results.out_row     = slots[head].out_row;
  assign results.out_value   = slots[head].out_value;
  assign results.kept_count  = slots[head].kept_count;
  assign results.last_result = slots[head].last_result;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CW'(RES_DEPTH))
    else $error("result queue overflow");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    accept && entries.column_end |=> !pending_valid && (column_kept == '0))
    else $error("column close left state behind");

  a_entry_pending: assert property (@(posedge clk) disable iff (rst)
    accept && entries.has_entry && !entries.column_end |=> pending_valid)
    else $error("entry not held as pending");

  a_kept_limit: assert property (@(posedge clk) disable iff (rst)
    column_kept <= KEPT_LIMIT)
    else $error("kept count above limit");

endmodule

`default_nettype wire

[tb/sparse_column_duplicate_merge_tb.sv]
// Testbench for sparse_column_duplicate_merge: drives CSC entry columns and checks each
// merged entry and column close against a cycle-free model of the merge.
// Depends on scdm_pkg, the channel interfaces in scdm_if.sv and the block itself.
`default_nettype none

module sparse_column_duplicate_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scdm_pkg::*;

  localparam int IDLE_MAX      = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scdm_cfg_if cfg_ch ();
  scdm_in_if  ent_ch ();
  scdm_out_if res_ch ();

  sparse_column_duplicate_merge dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .entries (ent_ch),
    .results (res_ch)
  );

  // model state
  combine_t            combine_sel = OP_SUM;
  logic                pend_valid  = 1'b0;
  logic [ROW_W-1:0]    pend_row    = '0;
  logic [VALUE_W-1:0]  pend_value  = '0;
  logic [COUNT_W-1:0]  col_kept    = '0;

  result_t merged_q[$];

  bit       src_idle     = 1'b0;
  bit       snk_idle     = 1'b0;
  int       entry_items  = 0;
  int       results_seen = 0;
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  bit [3:0] rules_used   = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] magnitude32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] combine_values(logic [31:0] acc, logic [31:0] add);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] pick;
    ma = magnitude32(acc);
    mb = magnitude32(add);
    case (combine_sel)
      OP_SUM:  return acc + add;
      OP_PROD: return acc * add;
      OP_AMAX: pick = (ma > mb) ? ma : mb;
      default: pick = (ma < mb) ? ma : mb;
    endcase
    // 2^31 has no positive form
    return (pick > 32'h7fffffff) ? 32'h7fffffff : pick;
  endfunction

  function automatic void push_result(result_kind_t kind, logic [ROW_W-1:0] row,
                                      logic [VALUE_W-1:0] val, logic [COUNT_W-1:0] cnt);
    result_t r;
    r.result_kind = kind;
    r.out_row     = row;
    r.out_value   = val;
    r.kept_count  = cnt;
    r.last_result = 1'b0;
    merged_q.push_back(r);
  endfunction

  function automatic void predict_item(logic has, logic [ROW_W-1:0] row,
                                       logic [VALUE_W-1:0] val, logic cend);
    int produced;
    produced = 0;
    if (has) begin
      if (pend_valid && pend_row == row) begin
        pend_value = combine_values(pend_value, val);
      end else begin
        if (pend_valid) begin
          push_result(KIND_ENTRY, pend_row, pend_value, '0);
          produced++;
        end
        pend_valid = 1'b1;
        pend_row   = row;
        pend_value = val;
        if (col_kept < KEPT_LIMIT) col_kept++;
      end
    end
    if (cend) begin
      if (pend_valid) begin
        push_result(KIND_ENTRY, pend_row, pend_value, '0);
        produced++;
      end
      push_result(KIND_CLOSE, '0, '0, col_kept);
      produced++;
      pend_valid = 1'b0;
      pend_row   = '0;
      pend_value = '0;
      col_kept   = '0;
    end
    if (produced > 0) merged_q[merged_q.size() - 1].last_result = 1'b1;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h80000000;
          1: return 32'h7fffffff;
          2: return 32'hffffffff;
          default: return 32'h0;
        endcase
      end
      1: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // valid stays high on return so back-to-back items need no re-raise
  task automatic send_item(logic has, logic [ROW_W-1:0] row, logic [VALUE_W-1:0] val,
                           logic cend);
    int gap;
    gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      ent_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ent_ch.valid       <= 1'b1;
    ent_ch.has_entry   <= has;
    ent_ch.row_index   <= row;
    ent_ch.entry_value <= val;
    ent_ch.column_end  <= cend;
    do @(posedge clk); while (ent_ch.ready !== 1'b1);
    predict_item(has, row, val, cend);
    if (has || cend) entry_items++;
  endtask

  task automatic drain_results();
    ent_ch.valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    // merge-only items leave no result behind to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_combine(combine_t op);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= op;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    combine_sel    = op;
    rules_used[op] = 1'b1;
  endtask

  task automatic test_sum_and_closes();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_combine(OP_SUM);
    send_item(1'b0, 16'h0000, 32'h00000000, 1'b1);  // bare close
    send_item(1'b0, 16'hffff, 32'hffffffff, 1'b0);  // neither flag
    send_item(1'b1, 16'h0000, 32'h7fffffff, 1'b0);
    send_item(1'b1, 16'h0000, 32'h00000001, 1'b0);  // sum wraps
    send_item(1'b1, 16'hffff, 32'h80000000, 1'b0);
    send_item(1'b1, 16'hffff, 32'hffffffff, 1'b1);  // merge then close
    send_item(1'b1, 16'h0005, 32'h00000011, 1'b0);
    send_item(1'b1, 16'h0009, 32'hfffffffd, 1'b1);  // pending, new entry and close
    send_item(1'b1, 16'h0001, 32'h00000001, 1'b0);
    send_item(1'b1, 16'h0002, 32'h00000002, 1'b0);
    send_item(1'b1, 16'h0001, 32'h00000003, 1'b0);  // repeat that is not a neighbour
    send_item(1'b0, 16'h0000, 32'h00000000, 1'b1);
  endtask

  task automatic test_product();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    write_combine(OP_PROD);
    send_item(1'b1, 16'h0003, 32'h00010000, 1'b0);
    send_item(1'b1, 16'h0003, 32'h00010000, 1'b0);  // wraps to zero
    send_item(1'b1, 16'h0004, 32'h7fffffff, 1'b0);
    send_item(1'b1, 16'h0004, 32'h7fffffff, 1'b1);
  endtask

  task automatic test_magnitude();
    src_idle = 1'b1;
    snk_idle = 1'b0;
    write_combine(OP_AMAX);
    send_item(1'b1, 16'h0002, 32'h80000000, 1'b0);
    send_item(1'b1, 16'h0002, 32'h00000005, 1'b1);  // saturates
    send_item(1'b1, 16'h0001, 32'hfffffff9, 1'b0);
    send_item(1'b1, 16'h0001, 32'h00000003, 1'b1);
    write_combine(OP_AMIN);
    send_item(1'b1, 16'h0002, 32'h80000000, 1'b0);
    send_item(1'b1, 16'h0002, 32'h80000000, 1'b0);  // saturates
    send_item(1'b1, 16'h0006, 32'hfffffff7, 1'b0);
    send_item(1'b1, 16'h0006, 32'h00000004, 1'b0);
    send_item(1'b1, 16'h0008, 32'h80000000, 1'b0);
    send_item(1'b1, 16'h0008, 32'hffffffff, 1'b1);
  endtask

  task automatic test_random_columns();
    int          first;
    int          nent;
    logic        cend;
    logic        closed;
    logic [15:0] row;
    first = entry_items;
    row   = '0;
    while (entry_items - first < RANDOM_ITEMS) begin
      write_combine(combine_t'(2'($urandom_range(0, 3))));
      src_idle = ($urandom_range(0, 2) != 0);
      snk_idle = ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 4)) begin
        nent   = $urandom_range(0, 6);
        closed = 1'b0;
        for (int i = 0; i < nent; i++) begin
          if ($urandom_range(0, 3) != 0)
            row = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom());
          if ($urandom_range(0, 9) == 0) send_item(1'b0, 16'($urandom()), $urandom(), 1'b0);
          cend = (i == nent - 1) && ($urandom_range(0, 2) != 0);
          send_item(1'b1, row, random_value(), cend);
          closed = cend;
        end
        if (!closed) send_item(1'b0, 16'($urandom()), $urandom(), 1'b1);
      end
    end
  endtask

  initial begin : result_sink
    int      stall;
    result_t want;
    forever begin
      stall = snk_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (rst !== 1'b0 || res_ch.valid !== 1'b1);
      results_seen++;
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected result: kind %0d row %0d value %h count %0d", $time,
                 res_ch.result_kind, res_ch.out_row, res_ch.out_value, res_ch.kept_count);
        mismatches++;
      end else begin
        want = merged_q.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(res_ch.result_kind));
        check_field("out_row", 32'(want.out_row), 32'(res_ch.out_row));
        check_field("out_value", want.out_value, res_ch.out_value);
        check_field("kept_count", 32'(want.kept_count), 32'(res_ch.kept_count));
        check_field("last_result", 32'(want.last_result), 32'(res_ch.last_result));
      end
    end
  end

  always @(posedge clk) begin
    if ((ent_ch.valid === 1'b1 && ent_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, merged_q.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ent_ch.valid       <= 1'b0;
    ent_ch.has_entry   <= 1'b0;
    ent_ch.row_index   <= '0;
    ent_ch.entry_value <= '0;
    ent_ch.column_end  <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= OP_SUM;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_sum_and_closes();
    test_product();
    test_magnitude();
    test_random_columns();
    drain_results();

    $display("summary: %0d entry items, %0d results checked, combine rules written %b",
             entry_items, results_seen, rules_used);
    $display("summary: wrap, magnitude saturation, bare closes and neighbour-only merges exercised");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
src/scdm_pkg.sv
src/scdm_if.sv
src/sparse_column_duplicate_merge.sv
tb/sparse_column_duplicate_merge_tb.sv
